@@ hw/rtl/p2oa_pkg.sv @@
// ----------------------------------------------------------------------------
// p2oa_pkg
// Shared types, codes and default sizes of the power-of-two offset allocator.
// ----------------------------------------------------------------------------
package p2oa_pkg;

  localparam int REGION_LOG2_DEF = 16;
  localparam int MIN_CLASS_DEF   = 3;
  localparam int MAX_CLASS_DEF   = 16;
  localparam int STACK_DEPTH_DEF = 64;

  localparam int OFF_W   = 16;
  localparam int BYTES_W = 16;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_LARGE  = 2'd1,
    ST_NO_MEMORY  = 2'd2,
    ST_STACK_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_DECIDE,
    S_SEARCH,
    S_POP_OWN,
    S_POP_SPLIT,
    S_SPLIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    set_class;
    logic    bump;
    logic    free_top;
    logic    push_free;
    logic    pop;
    logic    take_pop;
    logic    split_init;
    logic    split_step;
    logic    next_class;
    logic    set_stat;
    status_t stat;
  } dp_cmd_t;

  typedef struct packed {
    logic too_large;
    logic is_free;
    logic bump_ok;
    logic disabled;
    logic cnt_nz;
    logic cnt_full;
    logic at_top;
    logic search_end;
    logic split_last;
  } dp_status_t;

endpackage

@@ hw/rtl/p2oa_ram.sv @@
// ----------------------------------------------------------------------------
// p2oa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module p2oa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/p2oa_ctrl.sv @@
// ----------------------------------------------------------------------------
// p2oa_ctrl
// Sequencer of the allocator: steps one item through class lookup, decision,
// class search, pop and leftover splitting, then offers the result.
// ----------------------------------------------------------------------------
module p2oa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  p2oa_pkg::dp_status_t st,
  output p2oa_pkg::dp_cmd_t    cmd
);

  p2oa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= p2oa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      p2oa_pkg::S_IDLE:      if (in_valid) state_next = p2oa_pkg::S_CLASS;
      p2oa_pkg::S_CLASS:     state_next = p2oa_pkg::S_DECIDE;
      p2oa_pkg::S_DECIDE: begin
        if (st.too_large || st.is_free || st.bump_ok || st.disabled) begin
          state_next = p2oa_pkg::S_OUT;
        end else if (st.cnt_nz) begin
          state_next = p2oa_pkg::S_POP_OWN;
        end else begin
          state_next = p2oa_pkg::S_SEARCH;
        end
      end
      p2oa_pkg::S_SEARCH: begin
        if (st.search_end) begin
          state_next = p2oa_pkg::S_OUT;
        end else if (st.cnt_nz) begin
          state_next = p2oa_pkg::S_POP_SPLIT;
        end
      end
      p2oa_pkg::S_POP_OWN:   state_next = p2oa_pkg::S_OUT;
      p2oa_pkg::S_POP_SPLIT: state_next = p2oa_pkg::S_SPLIT;
      p2oa_pkg::S_SPLIT:     if (st.split_last) state_next = p2oa_pkg::S_OUT;
      p2oa_pkg::S_OUT:       if (out_ready) state_next = p2oa_pkg::S_IDLE;
      default:               state_next = p2oa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.stat  = p2oa_pkg::ST_OK;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      p2oa_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      p2oa_pkg::S_CLASS: cmd.set_class = 1'b1;
      p2oa_pkg::S_DECIDE: begin
        if (st.too_large) begin
          cmd.set_stat = 1'b1;
          cmd.stat     = p2oa_pkg::ST_TOO_LARGE;
        end else if (!st.is_free) begin
          if (st.bump_ok) begin
            cmd.bump = 1'b1;
          end else if (st.disabled) begin
            cmd.set_stat = 1'b1;
            cmd.stat     = p2oa_pkg::ST_NO_MEMORY;
          end else if (st.cnt_nz) begin
            cmd.pop = 1'b1;
          end else begin
            cmd.next_class = 1'b1;
          end
        end else begin
          if (st.at_top) begin
            cmd.free_top = 1'b1;
          end else if (!st.disabled) begin
            if (st.cnt_full) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = p2oa_pkg::ST_STACK_FULL;
            end else begin
              cmd.push_free = 1'b1;
            end
          end
        end
      end
      p2oa_pkg::S_SEARCH: begin
        if (st.search_end) begin
          cmd.set_stat = 1'b1;
          cmd.stat     = p2oa_pkg::ST_NO_MEMORY;
        end else if (st.cnt_nz) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.next_class = 1'b1;
        end
      end
      p2oa_pkg::S_POP_OWN: cmd.take_pop = 1'b1;
      p2oa_pkg::S_POP_SPLIT: begin
        cmd.take_pop   = 1'b1;
        cmd.split_init = 1'b1;
      end
      p2oa_pkg::S_SPLIT: cmd.split_step = 1'b1;
      p2oa_pkg::S_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/p2oa_dpath.sv @@
// ----------------------------------------------------------------------------
// p2oa_dpath
// Datapath of the allocator: top pointer, per-class counts, stack RAM and
// the registers of the item in flight.
// ----------------------------------------------------------------------------
module p2oa_dpath #(
  parameter int REGION_LOG2 = p2oa_pkg::REGION_LOG2_DEF,
  parameter int MIN_CLASS   = p2oa_pkg::MIN_CLASS_DEF,
  parameter int MAX_CLASS   = p2oa_pkg::MAX_CLASS_DEF,
  parameter int STACK_DEPTH = p2oa_pkg::STACK_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_data,
  input  logic                          in_command,
  input  logic [p2oa_pkg::BYTES_W-1:0]  in_bytes,
  input  logic [p2oa_pkg::OFF_W-1:0]    in_offset,
  output logic [p2oa_pkg::OFF_W-1:0]    res_offset,
  output p2oa_pkg::status_t             res_status,
  input  p2oa_pkg::dp_cmd_t             cmd,
  output p2oa_pkg::dp_status_t          st
);

  localparam int AW    = (REGION_LOG2 > p2oa_pkg::BYTES_W ? REGION_LOG2 : p2oa_pkg::BYTES_W) + 2;
  localparam int TOP_W = REGION_LOG2 + 1;
  localparam int CMAX  = MAX_CLASS > p2oa_pkg::BYTES_W ? MAX_CLASS : p2oa_pkg::BYTES_W;
  localparam int CW    = $clog2(CMAX + 1);
  localparam int CI_W  = $clog2(MAX_CLASS);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IX_W  = $clog2(STACK_DEPTH);
  localparam int RA_W  = $clog2(MAX_CLASS * STACK_DEPTH);

  logic                         disabled;
  logic                         cmd_reg;
  logic [p2oa_pkg::BYTES_W-1:0] bytes;
  logic [p2oa_pkg::OFF_W-1:0]   foff;
  logic [CW-1:0]                cls;
  logic [CW-1:0]                cur;
  logic [TOP_W-1:0]             top;
  logic [CNT_W-1:0]             counts [MAX_CLASS];
  logic [p2oa_pkg::OFF_W-1:0]   result;
  p2oa_pkg::status_t            stat;
  logic [AW-1:0]                start;

  logic [CI_W-1:0]              ci;
  logic                         cur_in;
  logic [CNT_W-1:0]             cnt_cur;
  logic [AW-1:0]                size;
  logic [RA_W-1:0]              base;
  logic                         ram_we;
  logic [RA_W-1:0]              waddr;
  logic [RA_W-1:0]              raddr;
  logic [p2oa_pkg::OFF_W-1:0]   wdata;
  logic [p2oa_pkg::OFF_W-1:0]   rdata;

  // Smallest class, not below the minimum, whose block holds the request.
  function automatic logic [CW-1:0] size_class(input logic [p2oa_pkg::BYTES_W-1:0] b);
    logic [CW-1:0] r;
    r = CW'(p2oa_pkg::BYTES_W);
    for (int c = p2oa_pkg::BYTES_W; c >= 0; c--) begin
      if ((AW'(1) << c) >= AW'(b)) r = CW'(c);
    end
    if (r < CW'(MIN_CLASS)) r = CW'(MIN_CLASS);
    return r;
  endfunction

  assign ci      = cur[CI_W-1:0];
  assign cur_in  = cur < CW'(MAX_CLASS);
  assign cnt_cur = cur_in ? counts[ci] : '0;
  assign size    = AW'(1) << cls;
  assign base    = RA_W'(ci) * RA_W'(STACK_DEPTH);

  assign ram_we = cmd.push_free || cmd.split_step;
  assign waddr  = base + RA_W'(cnt_cur[IX_W-1:0]);
  assign raddr  = base + RA_W'(IX_W'(cnt_cur - CNT_W'(1)));
  assign wdata  = cmd.split_step ? start[p2oa_pkg::OFF_W-1:0] : foff;

  assign st.too_large  = cls >= CW'(MAX_CLASS);
  assign st.is_free    = cmd_reg == p2oa_pkg::CMD_FREE;
  assign st.bump_ok    = (AW'(top) + size) <= (AW'(1) << REGION_LOG2);
  assign st.disabled   = disabled;
  assign st.cnt_nz     = cnt_cur != '0;
  assign st.cnt_full   = cnt_cur >= CNT_W'(STACK_DEPTH);
  assign st.at_top     = AW'(top) == (AW'(foff) + size);
  assign st.search_end = !cur_in;
  assign st.split_last = cur == cls;

  assign res_offset = result;
  assign res_status = stat;

  p2oa_ram #(
    .WIDTH (p2oa_pkg::OFF_W),
    .DEPTH (MAX_CLASS * STACK_DEPTH)
  ) u_stacks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      disabled <= 1'b0;
      top      <= '0;
      for (int i = 0; i < MAX_CLASS; i++) counts[i] <= '0;
    end else begin
      if (cfg_we) disabled <= cfg_data;
      if (cmd.bump) top <= TOP_W'(AW'(top) + size);
      if (cmd.free_top) top <= TOP_W'(foff);
      if (cmd.pop) counts[ci] <= cnt_cur - CNT_W'(1);
      if (ram_we) counts[ci] <= cnt_cur + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_reg <= in_command;
      bytes   <= in_bytes;
      foff    <= in_offset;
      result  <= '0;
      stat    <= p2oa_pkg::ST_OK;
    end
    if (cmd.set_class) begin
      cls <= size_class(bytes);
      cur <= size_class(bytes);
    end
    if (cmd.bump) result <= top[p2oa_pkg::OFF_W-1:0];
    if (cmd.set_stat) stat <= cmd.stat;
    if (cmd.next_class) cur <= cur + CW'(1);
    if (cmd.take_pop) result <= rdata;
    // leftover pieces run from the class below the popped one down to ours
    if (cmd.split_init) begin
      start <= AW'(rdata) + size;
      cur   <= cur - CW'(1);
    end
    if (cmd.split_step) begin
      start <= start + (AW'(1) << cur);
      if (cur != cls) cur <= cur - CW'(1);
    end
  end

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> cur_in && (cnt_cur < CNT_W'(STACK_DEPTH)))
    else $error("push into a full or absent class stack");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> cur_in && (cnt_cur != '0))
    else $error("pop from an empty class stack");

  a_top_in_region: assert property (@(posedge clk) disable iff (rst)
    AW'(top) <= (AW'(1) << REGION_LOG2))
    else $error("top pointer beyond region end");

  a_split_above: assert property (@(posedge clk) disable iff (rst)
    cmd.split_init |-> cur > cls)
    else $error("split started from a class not above the request");

endmodule

@@ hw/rtl/pow2_offset_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// pow2_offset_allocator_unit
// Power-of-two offset allocator with bump pointer and per-class free stacks.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An item that bumps the top pointer, is
// refused or is freed goes from class lookup to the decision and out; one
// that pops its own class passes a pop state first; otherwise the class
// search walks upward one class a cycle and the split pushes one leftover
// piece a cycle through the single write port of the stack RAM; idle follows
// the output handshake. The free-lists register must be written by the user
// through the cfg channel while no item is in flight; it is not enforced.
module pow2_offset_allocator_unit #(
  parameter int REGION_LOG2 = p2oa_pkg::REGION_LOG2_DEF,
  parameter int MIN_CLASS   = p2oa_pkg::MIN_CLASS_DEF,
  parameter int MAX_CLASS   = p2oa_pkg::MAX_CLASS_DEF,
  parameter int STACK_DEPTH = p2oa_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         free_lists_disabled,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic [p2oa_pkg::BYTES_W-1:0] request_bytes,
  input  logic [p2oa_pkg::OFF_W-1:0]   free_offset,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [p2oa_pkg::OFF_W-1:0]   alloc_offset,
  output logic [1:0]                   status
);

  p2oa_pkg::dp_cmd_t    cmd;
  p2oa_pkg::dp_status_t st;
  p2oa_pkg::status_t    res_status;

  assign cfg_ready = 1'b1;
  assign status    = res_status;

  p2oa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  p2oa_dpath #(
    .REGION_LOG2 (REGION_LOG2),
    .MIN_CLASS   (MIN_CLASS),
    .MAX_CLASS   (MAX_CLASS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid),
    .cfg_data   (free_lists_disabled),
    .in_command (command),
    .in_bytes   (request_bytes),
    .in_offset  (free_offset),
    .res_offset (alloc_offset),
    .res_status (res_status),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

@@ sim/tb_pow2_offset_allocator_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pow2_offset_allocator_unit
// Self-checking bench: a directed table followed by random phases of allocate
// and free items, checked against typed rows or an in-bench allocator model.
// ----------------------------------------------------------------------------
module tb_pow2_offset_allocator_unit;

  localparam int NUM_CLASSES = p2oa_pkg::MAX_CLASS_DEF;
  localparam int DEPTH       = p2oa_pkg::STACK_DEPTH_DEF;
  localparam int REGION      = 1 << p2oa_pkg::REGION_LOG2_DEF;
  localparam int DRAIN_WAIT  = 48;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 185;

  typedef struct {
    logic [p2oa_pkg::OFF_W-1:0] offset;
    p2oa_pkg::status_t          stat;
  } alloc_result_t;

  typedef struct packed {
    logic                       cmd;
    logic [15:0]                bytes;
    logic [15:0]                offset;
    logic                       typed;
    logic [p2oa_pkg::OFF_W-1:0] e_offset;
    p2oa_pkg::status_t          e_stat;
  } table_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic                       free_lists_disabled = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       command = p2oa_pkg::CMD_ALLOC;
  logic [15:0]                request_bytes = '0;
  logic [15:0]                free_offset = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [p2oa_pkg::OFF_W-1:0] alloc_offset;
  logic [1:0]                 status;

  // allocator model state
  int               top_ptr;
  logic [15:0]      class_stack [NUM_CLASSES][DEPTH];
  int               class_count [NUM_CLASSES];
  logic             lists_off;

  alloc_result_t    pending_results [$];
  int               live_offsets [$];
  int               live_bytes [$];
  int               errors = 0;
  int               cycles = 0;
  bit               no_idle = 1'b0;

  table_row_t directed_rows [20] = '{
    '{p2oa_pkg::CMD_ALLOC, 16'd0,     16'd0,     1'b1, 16'd0,     p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_ALLOC, 16'd1,     16'd0,     1'b1, 16'd8,     p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_ALLOC, 16'hFFFF,  16'd0,     1'b1, 16'd0,     p2oa_pkg::ST_TOO_LARGE},
    '{p2oa_pkg::CMD_FREE,  16'd40000, 16'hFFFF,  1'b1, 16'd0,     p2oa_pkg::ST_TOO_LARGE},
    '{p2oa_pkg::CMD_ALLOC, 16'd32768, 16'd0,     1'b1, 16'd16,    p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_FREE,  16'd32768, 16'd16,    1'b1, 16'd0,     p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_ALLOC, 16'd9,     16'hFFFF,  1'b1, 16'd16,    p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_FREE,  16'd8,     16'd0,     1'b1, 16'd0,     p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_FREE,  16'd16,    16'd16,    1'b1, 16'd0,     p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_ALLOC, 16'd8,     16'd0,     1'b1, 16'd16,    p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_ALLOC, 16'd32768, 16'd0,     1'b1, 16'd24,    p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_ALLOC, 16'd32768, 16'd0,     1'b1, 16'd0,     p2oa_pkg::ST_NO_MEMORY},
    '{p2oa_pkg::CMD_ALLOC, 16'd16384, 16'd0,     1'b1, 16'd32792, p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_ALLOC, 16'd16384, 16'd0,     1'b1, 16'd0,     p2oa_pkg::ST_NO_MEMORY},
    '{p2oa_pkg::CMD_ALLOC, 16'd8192,  16'd0,     1'b1, 16'd49176, p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_ALLOC, 16'd8192,  16'd0,     1'b1, 16'd0,     p2oa_pkg::ST_NO_MEMORY},
    '{p2oa_pkg::CMD_FREE,  16'd16384, 16'd32792, 1'b0, 16'd0,     p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_ALLOC, 16'd8192,  16'd0,     1'b0, 16'd0,     p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_ALLOC, 16'd8,     16'd0,     1'b0, 16'd0,     p2oa_pkg::ST_OK},
    '{p2oa_pkg::CMD_FREE,  16'hFFFF,  16'hFFFF,  1'b1, 16'd0,     p2oa_pkg::ST_TOO_LARGE}
  };

  pow2_offset_allocator_unit dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .free_lists_disabled (free_lists_disabled),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .command             (command),
    .request_bytes       (request_bytes),
    .free_offset         (free_offset),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .alloc_offset        (alloc_offset),
    .status              (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= 28);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", status, 0);
      end else begin
        exp_res = pending_results.pop_front();
        if (alloc_offset !== exp_res.offset)
          report_mismatch("alloc_offset", alloc_offset, exp_res.offset);
        if (status !== exp_res.stat)
          report_mismatch("status", status, exp_res.stat);
      end
    end
  end

  task automatic push_class(input int cls, input int off);
    class_stack[cls][class_count[cls]] = off[15:0];
    class_count[cls]++;
  endtask

  function automatic int pop_class(input int cls);
    class_count[cls]--;
    return class_stack[cls][class_count[cls]];
  endfunction

  // advance the allocator model by one item
  task automatic predict_alloc(input logic cmd, input int bytes, input int off,
                               output alloc_result_t res);
    int cls;
    int size;
    int k;
    int i;
    int start;
    int stop;
    cls = p2oa_pkg::MIN_CLASS_DEF;
    res.offset = '0;
    res.stat = p2oa_pkg::ST_OK;
    while (cls < 32 && (1 << cls) < bytes) cls++;
    if (cls >= NUM_CLASSES) begin
      res.stat = p2oa_pkg::ST_TOO_LARGE;
      return;
    end
    size = 1 << cls;
    if (cmd == p2oa_pkg::CMD_ALLOC) begin
      if (top_ptr + size <= REGION) begin
        res.offset = top_ptr[15:0];
        top_ptr += size;
      end else if (lists_off) begin
        res.stat = p2oa_pkg::ST_NO_MEMORY;
      end else if (class_count[cls] != 0) begin
        res.offset = 16'(pop_class(cls));
      end else begin
        k = cls;
        while (k < NUM_CLASSES && class_count[k] == 0) k++;
        if (k >= NUM_CLASSES) begin
          res.stat = p2oa_pkg::ST_NO_MEMORY;
        end else begin
          start = pop_class(k);
          res.offset = start[15:0];
          stop = start + (1 << k);
          start += size;
          i = k;
          // hand the leftover pieces down to the smaller classes
          while (start < stop && i > 0) begin
            i--;
            push_class(i, start);
            start += 1 << i;
          end
        end
      end
    end else begin
      if (top_ptr == off + size) begin
        top_ptr = off;
      end else if (!lists_off) begin
        if (class_count[cls] >= DEPTH) res.stat = p2oa_pkg::ST_STACK_FULL;
        else push_class(cls, off);
      end
    end
  endtask

  task automatic send_item(input logic cmd, input int bytes, input int off,
                           input bit typed, input alloc_result_t typed_res);
    alloc_result_t res;
    int idx;
    if (!no_idle && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    request_bytes <= bytes[15:0];
    free_offset   <= off[15:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_alloc(cmd, bytes, off, res);
    pending_results.insert(pending_results.size(), typed ? typed_res : res);
    // keep the list of live blocks in step for well-formed frees
    if (cmd == p2oa_pkg::CMD_ALLOC && res.stat == p2oa_pkg::ST_OK) begin
      live_offsets.insert(live_offsets.size(), int'(res.offset));
      live_bytes.insert(live_bytes.size(), bytes);
    end else if (cmd == p2oa_pkg::CMD_FREE) begin
      for (idx = 0; idx < live_offsets.size(); idx++) begin
        if (live_offsets[idx] == off && live_bytes[idx] == bytes) begin
          live_offsets.delete(idx);
          live_bytes.delete(idx);
          break;
        end
      end
    end
  endtask

  // hold off until every result has come, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_lists_off(input logic value);
    cfg_valid           <= 1'b1;
    free_lists_disabled <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    lists_off = value;
  endtask

  task automatic random_item(input bit fill_burst);
    alloc_result_t none;
    int pick;
    int bytes;
    int idx;
    none.offset = '0;
    none.stat = p2oa_pkg::ST_OK;
    pick = $urandom_range(0, 99);
    if (fill_burst) begin
      send_item(p2oa_pkg::CMD_FREE, $urandom_range(0, 8), $urandom_range(0, 65535),
                1'b0, none);
    end else if (pick < 15) begin
      // noise: any field value at all
      send_item(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                $urandom_range(0, 65535), 1'b0, none);
    end else if (pick < 55 && live_offsets.size() != 0) begin
      idx = $urandom_range(0, live_offsets.size() - 1);
      send_item(p2oa_pkg::CMD_FREE, live_bytes[idx], live_offsets[idx], 1'b0, none);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) bytes = $urandom_range(0, 256);
      else if (pick < 90) bytes = $urandom_range(0, 4096);
      else if (pick < 98) bytes = $urandom_range(0, 32768);
      else bytes = $urandom_range(32769, 65535);
      send_item(p2oa_pkg::CMD_ALLOC, bytes, $urandom_range(0, 65535), 1'b0, none);
    end
  endtask

  initial begin
    alloc_result_t typed_res;
    int row;
    int phase;
    int n;
    top_ptr = 0;
    lists_off = 1'b0;
    for (n = 0; n < NUM_CLASSES; n++) class_count[n] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < $size(directed_rows); row++) begin
      typed_res.offset = directed_rows[row].e_offset;
      typed_res.stat   = directed_rows[row].e_stat;
      send_item(directed_rows[row].cmd, directed_rows[row].bytes,
                directed_rows[row].offset, directed_rows[row].typed, typed_res);
    end

    for (phase = 0; phase < 5; phase++) begin
      drain_results();
      write_lists_off(phase[0]);
      no_idle = (phase == 2);
      for (n = 0; n < PHASE_ITEMS; n++)
        random_item(phase == 4 && n >= 40 && n < 115);
    end
    no_idle = 1'b0;
    drain_results();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
